FILE: rtl/core/dh_forward_kinematics_chain_defines.svh
// Assertion macros for the checker file of the kinematics chain.
// No dependencies; included by file name where assertions are written.
`ifndef DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH

// Condition now implies a consequence in the same cycle.
`define DHFK_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("dhfk check failed in the same cycle");

// Condition now implies a consequence in the following cycle.
`define DHFK_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("dhfk check failed on the following cycle");

`endif

FILE: rtl/core/dhfk_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the kinematics chain.
// No dependencies; used by every module and interface file through scoped names.
package dhfk_pkg;

	localparam int ANGLE_W      = 16;
	localparam int LEN_W        = 32;
	localparam int ENTRY_W      = 32;
	localparam int ENTRY_FRAC   = ENTRY_W - 2;
	localparam int CORDIC_FRAC  = 60;
	localparam int CORDIC_STEPS = 32;
	localparam int CORDIC_W     = 64;
	localparam int TURN_W       = 32;
	localparam int Z_W          = 33;
	localparam int ITER_W       = 5;
	localparam int OP_W         = 34;
	localparam int PROD_W       = 2 * OP_W;
	localparam int RND_W        = 36;
	localparam int ACC_W        = 40;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 64'sh09B7_4EDA_8000_0000;
	localparam logic signed [ENTRY_W-1:0]  ENTRY_ONE   = 32'sh4000_0000;

	typedef struct packed {
		logic signed [LEN_W-1:0]   link_length;
		logic signed [ANGLE_W-1:0] twist_angle;
		logic signed [LEN_W-1:0]   link_offset;
		logic signed [ANGLE_W-1:0] joint_angle;
		logic                      last_joint;
	} joint_item_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] rot_00;
		logic signed [ENTRY_W-1:0] rot_01;
		logic signed [ENTRY_W-1:0] rot_02;
		logic signed [ENTRY_W-1:0] rot_10;
		logic signed [ENTRY_W-1:0] rot_11;
		logic signed [ENTRY_W-1:0] rot_12;
		logic signed [ENTRY_W-1:0] rot_20;
		logic signed [ENTRY_W-1:0] rot_21;
		logic signed [ENTRY_W-1:0] rot_22;
		logic signed [LEN_W-1:0]   pos_x;
		logic signed [LEN_W-1:0]   pos_y;
		logic signed [LEN_W-1:0]   pos_z;
	} pose_item_t;

	typedef struct packed {
		logic        valid;
		joint_item_t item;
	} queue_head_t;

	typedef struct packed {
		logic               start;
		logic [ANGLE_W-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [ENTRY_W-1:0] cos_v;
		logic signed [ENTRY_W-1:0] sin_v;
	} cordic_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TH_GO,
		ST_TH_WAIT,
		ST_AL_GO,
		ST_AL_WAIT,
		ST_LINK,
		ST_LINK_DRAIN,
		ST_MAT,
		ST_MAT_DRAIN,
		ST_COMMIT
	} back_state_t;

	// Arctangent of 2^-i in units of 2^32 counts per turn.
	function automatic logic signed [Z_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

FILE: rtl/core/dhfk_if.sv
// Valid/ready channel interfaces for joint items and pose results.
// Depends on dhfk_pkg for the payload types.
interface dhfk_in_if;
	logic                 valid;
	logic                 ready;
	dhfk_pkg::joint_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dhfk_out_if;
	logic                valid;
	logic                ready;
	dhfk_pkg::pose_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/dh_forward_kinematics_chain.sv
// Top level of the Denavit-Hartenberg forward kinematics chain.
// Depends on dhfk_pkg, dhfk_if, dhfk_front, dhfk_cordic and dhfk_back.
//
//   Channel  Direction  Payload                         Item meaning
//   joints   in         a, alpha, d, theta, last flag   one joint of the chain
//   pose     out        3x3 rotation, x y z position    pose after the last joint
//
// In the back end each joint item takes two passes of the
// 32-step CORDIC (theta, then alpha) and 42 products through the one shared
// multiplier, six for the link transform and 36 for the matrix update.
// The front queue holds two items, so the source is released while a joint is worked on.
// Reset is asynchronous and active low; it sets the running transform to identity.
// A result waits in the output register; only a last joint stalls while it is still full.
module dh_forward_kinematics_chain (
	input  logic        clk,
	input  logic        arst_n,
	dhfk_in_if.sink     joints,
	dhfk_out_if.source  pose
);

	// Head of the joint queue, seen by the back end.
	dhfk_pkg::queue_head_t head;
	logic                  pop;

	// Sine/cosine unit shared by both angles of a joint.
	dhfk_pkg::cordic_req_t creq;
	dhfk_pkg::cordic_rsp_t crsp;

	dhfk_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.joints (joints),
		.pop    (pop),
		.head   (head)
	);

	dhfk_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	// The back end sequences the link transform, the matrix update and the
	// hand-over of the finished pose, one joint at a time.
	dhfk_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.creq   (creq),
		.crsp   (crsp),
		.pose   (pose)
	);

endmodule

FILE: rtl/core/dhfk_front.sv
// Front end: accepts joint items and holds them in a two-entry queue for the back end.
// Depends on dhfk_pkg and dhfk_in_if.
module dhfk_front (
	input  logic                   clk,
	input  logic                   arst_n,
	dhfk_in_if.sink                joints,
	input  logic                   pop,
	output dhfk_pkg::queue_head_t  head
);

	dhfk_pkg::joint_item_t             mem_q [dhfk_pkg::QUEUE_DEPTH];
	logic [dhfk_pkg::QPTR_W-1:0]       wr_q;
	logic [dhfk_pkg::QPTR_W-1:0]       rd_q;
	logic [dhfk_pkg::QCNT_W-1:0]       count_q;
	logic                              push;
	logic                              take;

	assign joints.ready = (count_q != dhfk_pkg::QCNT_W'(dhfk_pkg::QUEUE_DEPTH));
	assign push         = joints.valid && joints.ready;
	assign take         = pop && (count_q != '0);
	assign head.valid   = (count_q != '0);
	assign head.item    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= joints.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (take) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/dhfk_cordic.sv
// Iterative CORDIC giving the cosine and sine of a binary angle, one step per cycle.
// Depends on dhfk_pkg for widths and the arctangent table.
module dhfk_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dhfk_pkg::cordic_req_t req,
	output dhfk_pkg::cordic_rsp_t rsp
);

	localparam int SH = dhfk_pkg::CORDIC_FRAC - dhfk_pkg::ENTRY_FRAC;
	localparam logic signed [dhfk_pkg::CORDIC_W-1:0] HALF =
		dhfk_pkg::CORDIC_W'(1) << (SH - 1);

	logic signed [dhfk_pkg::CORDIC_W-1:0] x_q, y_q, dx, dy, xr, yr;
	logic signed [dhfk_pkg::Z_W-1:0]      z_q;
	logic [dhfk_pkg::ITER_W-1:0]          iter_q;
	logic [1:0]                           quad_q;
	logic                                 busy_q, done_q;
	logic [dhfk_pkg::TURN_W-1:0]          turn;
	logic signed [dhfk_pkg::ENTRY_W-1:0]  xe, ye;

	assign turn = dhfk_pkg::TURN_W'(req.angle) << (dhfk_pkg::TURN_W - dhfk_pkg::ANGLE_W);
	assign dx   = y_q >>> iter_q;
	assign dy   = x_q >>> iter_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			quad_q <= turn[dhfk_pkg::TURN_W-1 -: 2];
			z_q    <= dhfk_pkg::Z_W'(turn[dhfk_pkg::TURN_W-3:0]);
			x_q    <= dhfk_pkg::CORDIC_GAIN;
			y_q    <= '0;
		end else if (busy_q) begin
			if (!z_q[dhfk_pkg::Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - dhfk_pkg::atan_turn(iter_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + dhfk_pkg::atan_turn(iter_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == dhfk_pkg::ITER_W'(dhfk_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Round half up to the entry scale, then fold in the quadrant exactly.
	assign xr = (x_q + HALF) >>> SH;
	assign yr = (y_q + HALF) >>> SH;
	assign xe = xr[dhfk_pkg::ENTRY_W-1:0];
	assign ye = yr[dhfk_pkg::ENTRY_W-1:0];

	always_comb begin
		rsp.done = done_q;
		case (quad_q)
			2'd0: begin rsp.cos_v = xe;  rsp.sin_v = ye;  end
			2'd1: begin rsp.cos_v = -ye; rsp.sin_v = xe;  end
			2'd2: begin rsp.cos_v = -xe; rsp.sin_v = -ye; end
			default: begin rsp.cos_v = ye; rsp.sin_v = -xe; end
		endcase
	end

endmodule

FILE: rtl/core/dhfk_back.sv
// Back end: builds each link transform and folds it into the running pose with one multiplier.
// Depends on dhfk_pkg, dhfk_out_if and the request/response of dhfk_cordic.
module dhfk_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dhfk_pkg::queue_head_t head,
	output logic                  pop,
	output dhfk_pkg::cordic_req_t creq,
	input  dhfk_pkg::cordic_rsp_t crsp,
	dhfk_out_if.source            pose
);

	typedef struct packed {
		logic       valid;
		logic       is_link;
		logic [2:0] lidx;
		logic [1:0] i;
		logic [1:0] j;
		logic [1:0] k;
	} mul_tag_t;

	localparam int OP_W  = dhfk_pkg::OP_W;
	localparam int ACC_W = dhfk_pkg::ACC_W;
	localparam logic signed [dhfk_pkg::PROD_W-1:0] RND_HALF =
		dhfk_pkg::PROD_W'(1) << (dhfk_pkg::ENTRY_FRAC - 1);
	localparam logic signed [ACC_W-1:0] E_HI =
		{{(ACC_W - dhfk_pkg::ENTRY_W + 1){1'b0}}, {(dhfk_pkg::ENTRY_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] E_LO =
		{{(ACC_W - dhfk_pkg::ENTRY_W + 1){1'b1}}, {(dhfk_pkg::ENTRY_W - 1){1'b0}}};
	localparam logic signed [ACC_W-1:0] L_HI =
		{{(ACC_W - dhfk_pkg::LEN_W + 1){1'b0}}, {(dhfk_pkg::LEN_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] L_LO =
		{{(ACC_W - dhfk_pkg::LEN_W + 1){1'b1}}, {(dhfk_pkg::LEN_W - 1){1'b0}}};

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'({r, 1'b0}) + 4'(r) + 4'(c);
	endfunction

	function automatic logic signed [dhfk_pkg::ENTRY_W-1:0] sat_entry(
		input logic signed [ACC_W-1:0] v);
		if (v > E_HI) return E_HI[dhfk_pkg::ENTRY_W-1:0];
		if (v < E_LO) return E_LO[dhfk_pkg::ENTRY_W-1:0];
		return v[dhfk_pkg::ENTRY_W-1:0];
	endfunction

	function automatic logic signed [dhfk_pkg::LEN_W-1:0] sat_len(
		input logic signed [ACC_W-1:0] v);
		if (v > L_HI) return L_HI[dhfk_pkg::LEN_W-1:0];
		if (v < L_LO) return L_LO[dhfk_pkg::LEN_W-1:0];
		return v[dhfk_pkg::LEN_W-1:0];
	endfunction

	dhfk_pkg::back_state_t state_q, state_d;
	dhfk_pkg::joint_item_t item_q;

	logic signed [dhfk_pkg::ENTRY_W-1:0] ct_q, st_q;
	logic signed [OP_W-1:0]              lnk_q [9];
	logic signed [OP_W-1:0]              lt_q  [3];
	logic signed [dhfk_pkg::ENTRY_W-1:0] rot_q [9];
	logic signed [dhfk_pkg::LEN_W-1:0]   pos_q [3];
	logic signed [dhfk_pkg::ENTRY_W-1:0] nr_q  [9];
	logic signed [dhfk_pkg::LEN_W-1:0]   np_q  [3];

	logic [2:0] lstep_q;
	logic [1:0] mi_q, mj_q, mk_q;
	logic       mat_last;

	logic signed [OP_W-1:0]               op_a, op_b;
	mul_tag_t                             iss, tag_s1, tag_s2;
	logic signed [dhfk_pkg::PROD_W-1:0]   prod_s1, rsum;
	logic signed [dhfk_pkg::RND_W-1:0]    rnd_s2;
	logic signed [ACC_W-1:0]              acc_q, base, sum;

	logic out_valid_q, out_free, commit, pipe_empty;
	dhfk_pkg::pose_item_t out_q;

	assign out_free   = !out_valid_q || pose.ready;
	assign pipe_empty = !tag_s1.valid && !tag_s2.valid;
	assign mat_last   = (mi_q == 2'd2) && (mj_q == 2'd3) && (mk_q == 2'd2);
	assign pose.valid = out_valid_q;
	assign pose.data  = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dhfk_pkg::ST_IDLE:       if (head.valid) state_d = dhfk_pkg::ST_TH_GO;
			dhfk_pkg::ST_TH_GO:      state_d = dhfk_pkg::ST_TH_WAIT;
			dhfk_pkg::ST_TH_WAIT:    if (crsp.done) state_d = dhfk_pkg::ST_AL_GO;
			dhfk_pkg::ST_AL_GO:      state_d = dhfk_pkg::ST_AL_WAIT;
			dhfk_pkg::ST_AL_WAIT:    if (crsp.done) state_d = dhfk_pkg::ST_LINK;
			dhfk_pkg::ST_LINK:       if (lstep_q == 3'd5) state_d = dhfk_pkg::ST_LINK_DRAIN;
			dhfk_pkg::ST_LINK_DRAIN: if (pipe_empty) state_d = dhfk_pkg::ST_MAT;
			dhfk_pkg::ST_MAT:        if (mat_last) state_d = dhfk_pkg::ST_MAT_DRAIN;
			dhfk_pkg::ST_MAT_DRAIN:  if (pipe_empty) state_d = dhfk_pkg::ST_COMMIT;
			dhfk_pkg::ST_COMMIT: begin
				if (!item_q.last_joint || out_free) state_d = dhfk_pkg::ST_IDLE;
			end
			default:                 state_d = dhfk_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop, CORDIC request, multiplier issue and commit.
	always_comb begin
		pop        = 1'b0;
		creq.start = 1'b0;
		creq.angle = item_q.joint_angle;
		commit     = 1'b0;
		iss        = '0;
		op_a       = '0;
		op_b       = '0;
		case (state_q)
			dhfk_pkg::ST_IDLE:  pop = head.valid;
			dhfk_pkg::ST_TH_GO: creq.start = 1'b1;
			dhfk_pkg::ST_AL_GO: begin
				creq.start = 1'b1;
				creq.angle = item_q.twist_angle;
			end
			dhfk_pkg::ST_LINK: begin
				iss.valid   = 1'b1;
				iss.is_link = 1'b1;
				iss.lidx    = lstep_q;
				case (lstep_q)
					3'd0: begin op_a = OP_W'(st_q); op_b = lnk_q[8]; end
					3'd1: begin op_a = OP_W'(st_q); op_b = lnk_q[7]; end
					3'd2: begin op_a = OP_W'(ct_q); op_b = lnk_q[8]; end
					3'd3: begin op_a = OP_W'(ct_q); op_b = lnk_q[7]; end
					3'd4: begin op_a = OP_W'(item_q.link_length); op_b = OP_W'(ct_q); end
					default: begin op_a = OP_W'(item_q.link_length); op_b = OP_W'(st_q); end
				endcase
			end
			dhfk_pkg::ST_MAT: begin
				iss.valid = 1'b1;
				iss.i     = mi_q;
				iss.j     = mj_q;
				iss.k     = mk_q;
				op_a      = OP_W'(rot_q[idx3(mi_q, mk_q)]);
				if (mj_q == 2'd3) begin
					op_b = lt_q[mk_q];
				end else begin
					op_b = lnk_q[idx3(mk_q, mj_q)];
				end
			end
			dhfk_pkg::ST_COMMIT: commit = !item_q.last_joint || out_free;
			default: ;
		endcase
	end

	// Round half away from zero: add half, less one for negative products, then floor.
	assign rsum = prod_s1 + RND_HALF - dhfk_pkg::PROD_W'(prod_s1[dhfk_pkg::PROD_W-1]);

	assign base = (tag_s2.j == 2'd3) ? ACC_W'(pos_q[tag_s2.i]) : '0;
	assign sum  = ((tag_s2.k == 2'd0) ? base : acc_q) + ACC_W'(rnd_s2);

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head.item;
		end
		if (state_q == dhfk_pkg::ST_TH_WAIT && crsp.done) begin
			ct_q <= crsp.cos_v;
			st_q <= crsp.sin_v;
		end
		if (state_q == dhfk_pkg::ST_AL_WAIT && crsp.done) begin
			lnk_q[0] <= OP_W'(ct_q);
			lnk_q[3] <= OP_W'(st_q);
			lnk_q[6] <= '0;
			lnk_q[7] <= OP_W'(crsp.sin_v);
			lnk_q[8] <= OP_W'(crsp.cos_v);
			lt_q[2]  <= OP_W'(item_q.link_offset);
		end
		prod_s1 <= op_a * op_b;
		rnd_s2  <= rsum[dhfk_pkg::ENTRY_FRAC + dhfk_pkg::RND_W - 1 : dhfk_pkg::ENTRY_FRAC];
		if (tag_s2.valid && tag_s2.is_link) begin
			case (tag_s2.lidx)
				3'd0: lnk_q[1] <= OP_W'(-rnd_s2);
				3'd1: lnk_q[2] <= OP_W'(rnd_s2);
				3'd2: lnk_q[4] <= OP_W'(rnd_s2);
				3'd3: lnk_q[5] <= OP_W'(-rnd_s2);
				3'd4: lt_q[0]  <= OP_W'(rnd_s2);
				default: lt_q[1] <= OP_W'(rnd_s2);
			endcase
		end
		if (tag_s2.valid && !tag_s2.is_link) begin
			acc_q <= sum;
			if (tag_s2.k == 2'd2) begin
				if (tag_s2.j == 2'd3) begin
					np_q[tag_s2.i] <= sat_len(sum);
				end else begin
					nr_q[idx3(tag_s2.i, tag_s2.j)] <= sat_entry(sum);
				end
			end
		end
		if (commit && item_q.last_joint) begin
			out_q.rot_00 <= nr_q[0];
			out_q.rot_01 <= nr_q[1];
			out_q.rot_02 <= nr_q[2];
			out_q.rot_10 <= nr_q[3];
			out_q.rot_11 <= nr_q[4];
			out_q.rot_12 <= nr_q[5];
			out_q.rot_20 <= nr_q[6];
			out_q.rot_21 <= nr_q[7];
			out_q.rot_22 <= nr_q[8];
			out_q.pos_x  <= np_q[0];
			out_q.pos_y  <= np_q[1];
			out_q.pos_z  <= np_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dhfk_pkg::ST_IDLE;
			lstep_q     <= '0;
			mi_q        <= '0;
			mj_q        <= '0;
			mk_q        <= '0;
			tag_s1      <= '0;
			tag_s2      <= '0;
			out_valid_q <= 1'b0;
			for (int n = 0; n < 9; n++) begin
				rot_q[n] <= (n % 4 == 0) ? dhfk_pkg::ENTRY_ONE : '0;
			end
			for (int n = 0; n < 3; n++) begin
				pos_q[n] <= '0;
			end
		end else begin
			state_q <= state_d;
			tag_s1  <= iss;
			tag_s2  <= tag_s1;
			if (state_q == dhfk_pkg::ST_AL_WAIT) begin
				lstep_q <= '0;
			end else if (state_q == dhfk_pkg::ST_LINK) begin
				lstep_q <= lstep_q + 1'b1;
			end
			if (state_q == dhfk_pkg::ST_LINK_DRAIN) begin
				mi_q <= '0;
				mj_q <= '0;
				mk_q <= '0;
			end else if (state_q == dhfk_pkg::ST_MAT) begin
				if (mk_q == 2'd2) begin
					mk_q <= '0;
					if (mj_q == 2'd3) begin
						mj_q <= '0;
						mi_q <= mi_q + 1'b1;
					end else begin
						mj_q <= mj_q + 1'b1;
					end
				end else begin
					mk_q <= mk_q + 1'b1;
				end
			end
			if (commit) begin
				for (int n = 0; n < 9; n++) begin
					if (item_q.last_joint) begin
						rot_q[n] <= (n % 4 == 0) ? dhfk_pkg::ENTRY_ONE : '0;
					end else begin
						rot_q[n] <= nr_q[n];
					end
				end
				for (int n = 0; n < 3; n++) begin
					pos_q[n] <= item_q.last_joint ? '0 : np_q[n];
				end
			end
			if (commit && item_q.last_joint) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/dhfk_checker.sv
// Port-level checks of the kinematics chain, bound to the top level.
// Depends on dhfk_pkg and the assertion macros header.
`include "dh_forward_kinematics_chain_defines.svh"

module dhfk_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input dhfk_pkg::pose_item_t out_data
);

	logic in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	`DHFK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`DHFK_ASSERT_NEXT(a_queue_depth, clk, arst_n, in_acc ##1 in_acc ##1 in_acc, !in_acc)
	`DHFK_ASSERT_NEXT(a_result_spacing, clk, arst_n, out_acc ##1 out_acc, !out_acc)
	`DHFK_ASSERT_NOW(a_ready_drop, clk, arst_n, !in_ready, $past(in_acc) || $past(!in_ready))

endmodule

bind dh_forward_kinematics_chain dhfk_checker u_dhfk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (joints.valid),
	.in_ready  (joints.ready),
	.out_valid (pose.valid),
	.out_ready (pose.ready),
	.out_data  (pose.data)
);
